[rtl/core/ffs_pkg.sv]
// Shared types, codes and defaults of the first-fit suballocator.
`default_nettype none

package ffs_pkg;

  localparam int unsigned FreeSlotsDflt  = 16;
  localparam int unsigned OffsetBitsDflt = 32;

  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;

  // APB: one register at byte address 0, word index in paddr[2]
  localparam int unsigned CfgAddrW  = 3;
  localparam logic [0:0]  RegPoolSize = 1'b0;
  localparam logic [DataW-1:0] PoolSizeRst = 32'd20971520;

  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StNoSpace  = 2'd1,
    StListFull = 2'd2
  } status_e;

  typedef enum logic {
    KindAlloc   = 1'b0,
    KindRelease = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    SIdle   = 3'b001,
    SScan   = 3'b010,
    SFinish = 3'b100
  } state_e;

  typedef struct packed {
    logic fit;
    logic exact;
    logic merge;
  } slot_flags_t;

endpackage

`default_nettype wire

[rtl/core/ffs_if.sv]
// Request and response channel interfaces of the first-fit suballocator.
`default_nettype none

interface ffs_req_if import ffs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [DataW-1:0] block_size;
  logic [DataW-1:0] block_offset;

  modport source (output valid, kind, block_size, block_offset, input ready);
  modport sink   (input valid, kind, block_size, block_offset, output ready);
endinterface

interface ffs_rsp_if import ffs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DataW-1:0]   grant_offset;
  logic [StatusW-1:0] status;

  modport source (output valid, grant_offset, status, input ready);
  modport sink   (input valid, grant_offset, status, output ready);
endinterface

`default_nettype wire

[rtl/core/ffs_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module ffs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/ffs_slot_unit.sv]
// Shared compare and update unit applied to one free slot per cycle.
`default_nettype none

module ffs_slot_unit import ffs_pkg::*; #(
  parameter int unsigned OffsetBits = OffsetBitsDflt
) (
  input  wire logic                  kind_i,      // allocate or release
  input  wire logic [OffsetBits-1:0] slot_ofs_i,
  input  wire logic [OffsetBits-1:0] slot_size_i,
  input  wire logic [OffsetBits-1:0] arg_a_i,     // need, or block offset
  input  wire logic [OffsetBits-1:0] arg_b_i,     // block size
  output slot_flags_t                flags_o,
  output logic      [OffsetBits-1:0] upd_ofs_o,
  output logic      [OffsetBits-1:0] upd_size_o
);

  logic [OffsetBits-1:0] add_x;
  logic [OffsetBits-1:0] slot_sum;
  logic [OffsetBits:0]   diff;
  logic [OffsetBits-1:0] blk_end;
  logic                  is_rel;

  always_comb begin
    is_rel   = (kind_i == KindRelease);
    // slot end on release, shrunk slot start on allocate
    add_x    = is_rel ? slot_size_i : arg_a_i;
    slot_sum = slot_ofs_i + add_x;
    diff     = {1'b0, slot_size_i} - {1'b0, arg_a_i};
    blk_end  = arg_a_i + arg_b_i;

    flags_o.fit   = ~diff[OffsetBits];
    flags_o.exact = (slot_size_i == arg_a_i);
    flags_o.merge = (slot_sum == arg_a_i) || (slot_ofs_i == blk_end);

    if (is_rel) begin
      upd_ofs_o  = (slot_ofs_i < arg_a_i) ? slot_ofs_i : arg_a_i;
      upd_size_o = slot_size_i + arg_b_i;
    end else begin
      upd_ofs_o  = slot_sum;
      upd_size_o = diff[OffsetBits-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/core/ffs_cfg.sv]
// APB configuration register block holding the pool size.
`default_nettype none

module ffs_cfg import ffs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [DataW-1:0]    pwdata,
  output logic      [DataW-1:0]    prdata,
  output logic                     pready,
  output logic      [DataW-1:0]    pool_size_o
);

  logic [DataW-1:0] pool_size_q;
  logic             sel_pool;

  assign pready   = 1'b1;
  assign sel_pool = (paddr[CfgAddrW-1:2] == RegPoolSize);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= PoolSizeRst;
    end else if (psel && penable && pwrite && pready && sel_pool) begin
      pool_size_q <= pwdata;
    end
  end

  assign prdata      = sel_pool ? pool_size_q : '0;
  assign pool_size_o = pool_size_q;

endmodule

`default_nettype wire

[rtl/core/first_fit_suballocator.sv]
// Top level of the first-fit suballocator: sequencer, free-slot RAM and output register.
`default_nettype none

// Channel   Dir  Handshake     Payload
// req_i     in   valid/ready   kind, block_size, block_offset
// rsp_o     out  valid/ready   grant_offset, status
// apb       in   psel/penable  paddr, pwdata -> prdata (pready tied high)
//
// An item is accepted in idle, then its scan reads one listed free slot per cycle
// through the single RAM read port, and a finish state loads the response register.
// A release that ends at the top pointer, or any item on an empty list, skips the scan.
// Reset clears the slot count and top pointer and restores the default pool
// size; the slot RAM needs no clearing since only the first slot_count entries
// are ever read.
// A stalled response holds in the output register; the next request is still
// taken, and its finish waits until the output register frees up.

module first_fit_suballocator import ffs_pkg::*; #(
  parameter int unsigned FREE_SLOTS  = FreeSlotsDflt,
  parameter int unsigned OFFSET_BITS = OffsetBitsDflt
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  ffs_req_if.sink                  req_i,
  ffs_rsp_if.source                rsp_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [DataW-1:0]    pwdata,
  output logic      [DataW-1:0]    prdata,
  output logic                     pready
);

  localparam int unsigned OB   = OFFSET_BITS;
  localparam int unsigned IW   = $clog2(FREE_SLOTS);
  localparam int unsigned CNTW = $clog2(FREE_SLOTS + 1);
  // compare width that holds both the 32-bit pool size and an offset
  localparam int unsigned CW   = (OB > DataW) ? OB : DataW;
  localparam logic [CNTW-1:0] CntFull = CNTW'(FREE_SLOTS);
  localparam logic [CNTW-1:0] CntOne  = CNTW'(1);

  // ---------------------------------------------------------------- config
  logic [DataW-1:0] pool_size;

  ffs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .pool_size_o (pool_size)
  );

  // ---------------------------------------------------------------- state
  state_e          state_q, state_d;
  logic            kind_q;
  logic [OB-1:0]   need_q;     // allocation size, or merged block size
  logic [OB-1:0]   ofs_q;      // granted offset, or merged block offset
  logic            found_q;
  logic            at_top_q;
  logic [CNTW-1:0] rd_ptr_q;
  logic [CNTW-1:0] wr_ptr_q;
  logic [CNTW-1:0] count_q;
  logic [OB-1:0]   top_q;

  logic               rsp_valid_q;
  logic [DataW-1:0]   grant_q;
  status_e            status_q;

  // ---------------------------------------------------------------- input widening
  logic [CW-1:0] sz_ext, ofs_ext;
  logic [OB-1:0] sz_in, ofs_in;
  logic          in_fire;
  logic          in_at_top;

  assign sz_ext    = CW'(req_i.block_size);
  assign ofs_ext   = CW'(req_i.block_offset);
  assign sz_in     = sz_ext[OB-1:0];
  assign ofs_in    = ofs_ext[OB-1:0];
  assign req_i.ready = (state_q == SIdle);
  assign in_fire   = req_i.valid && req_i.ready;
  assign in_at_top = (req_i.kind == KindRelease) && ((ofs_in + sz_in) == top_q);

  // ---------------------------------------------------------------- slot RAM
  logic               ram_we;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  logic [2*OB-1:0]    ram_wdata, ram_rdata;
  logic [OB-1:0]      slot_ofs, slot_size;

  ffs_ram #(
    .Width (2 * OB),
    .Depth (FREE_SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign slot_ofs  = ram_rdata[2*OB-1:OB];
  assign slot_size = ram_rdata[OB-1:0];

  // ---------------------------------------------------------------- shared slot unit
  slot_flags_t   flags;
  logic [OB-1:0] upd_ofs, upd_size;
  logic [OB-1:0] arg_a;

  // allocate compares against the need, release against the grown block
  assign arg_a = (kind_q == KindRelease) ? ofs_q : need_q;

  ffs_slot_unit #(
    .OffsetBits (OB)
  ) u_unit (
    .kind_i      (kind_q),
    .slot_ofs_i  (slot_ofs),
    .slot_size_i (slot_size),
    .arg_a_i     (arg_a),
    .arg_b_i     (need_q),
    .flags_o     (flags),
    .upd_ofs_o   (upd_ofs),
    .upd_size_o  (upd_size)
  );

  // ---------------------------------------------------------------- top room check
  logic [CW-1:0] pool_ext, top_ext, room;
  logic          top_fits;

  always_comb begin
    pool_ext = CW'(pool_size);
    top_ext  = CW'(top_q);
    room     = (pool_ext > top_ext) ? (pool_ext - top_ext) : '0;
    top_fits = (CW'(need_q) <= room);
  end

  // ---------------------------------------------------------------- sequencer
  logic            scan_last;
  logic            out_free;
  logic [CW-1:0]   top_grant_ext;
  logic [CNTW-1:0] rd_next;

  assign scan_last     = (rd_ptr_q == (count_q - CntOne));
  assign out_free      = !rsp_valid_q || rsp_o.ready;
  assign top_grant_ext = CW'(top_q);
  assign rd_next       = rd_ptr_q + CntOne;

  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = wr_ptr_q[IW-1:0];
    ram_wdata = {slot_ofs, slot_size};
    ram_raddr = '0;
    case (state_q)
      SIdle: begin
        // read slot 0 now so the scan starts with its data
        if (in_fire) begin
          if (in_at_top || (count_q == '0)) begin
            state_d = SFinish;
          end else begin
            state_d = SScan;
          end
        end
      end
      SScan: begin
        ram_raddr = scan_last ? '0 : rd_next[IW-1:0];
        if (kind_q == KindAlloc) begin
          if (!found_q && flags.fit) begin
            // shrink the fitting slot from its front, drop it on exact fit
            ram_we    = !flags.exact;
            ram_wdata = {upd_ofs, upd_size};
          end else begin
            ram_we = 1'b1;
          end
        end else begin
          // compact: keep slots that do not merge
          ram_we = !flags.merge;
        end
        if (scan_last) begin
          state_d = SFinish;
        end
      end
      SFinish: begin
        if (out_free) begin
          state_d = SIdle;
          if ((kind_q == KindRelease) && !at_top_q && (wr_ptr_q != CntFull)) begin
            ram_we    = 1'b1;
            ram_wdata = {ofs_q, need_q};
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      count_q     <= '0;
      top_q       <= '0;
      rsp_valid_q <= 1'b0;
      found_q     <= 1'b0;
      at_top_q    <= 1'b0;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
    end else begin
      state_q <= state_d;
      // load a new response on finish, else drop the taken one
      if ((state_q == SFinish) && out_free) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (in_fire) begin
            found_q  <= 1'b0;
            at_top_q <= in_at_top;
            rd_ptr_q <= '0;
            wr_ptr_q <= '0;
          end
        end
        SScan: begin
          rd_ptr_q <= rd_next;
          if (ram_we) begin
            wr_ptr_q <= wr_ptr_q + CntOne;
          end
          if ((kind_q == KindAlloc) && flags.fit) begin
            found_q <= 1'b1;
          end
        end
        SFinish: begin
          if (out_free) begin
            if (kind_q == KindAlloc) begin
              count_q <= wr_ptr_q;
              if (!found_q && top_fits) begin
                top_q <= top_q + need_q;
              end
            end else if (at_top_q) begin
              top_q <= top_q - need_q;
            end else if (wr_ptr_q == CntFull) begin
              count_q <= wr_ptr_q;
            end else begin
              count_q <= wr_ptr_q + CntOne;
            end
          end
        end
        default: begin
          found_q <= 1'b0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      SIdle: begin
        if (in_fire) begin
          kind_q <= req_i.kind;
          need_q <= sz_in;
          ofs_q  <= (req_i.kind == KindRelease) ? ofs_in : '0;
        end
      end
      SScan: begin
        if (kind_q == KindAlloc) begin
          // hold the first fitting slot's start as the grant
          if (!found_q && flags.fit) begin
            ofs_q <= slot_ofs;
          end
        end else if (flags.merge) begin
          ofs_q  <= upd_ofs;
          need_q <= upd_size;
        end
      end
      SFinish: begin
        if (out_free) begin
          if (kind_q == KindAlloc) begin
            if (found_q) begin
              grant_q  <= DataW'(CW'(ofs_q));
              status_q <= StOk;
            end else if (top_fits) begin
              grant_q  <= top_grant_ext[DataW-1:0];
              status_q <= StOk;
            end else begin
              grant_q  <= '0;
              status_q <= StNoSpace;
            end
          end else begin
            grant_q  <= '0;
            status_q <= (!at_top_q && (wr_ptr_q == CntFull)) ? StListFull : StOk;
          end
        end
      end
      default: begin
        grant_q <= '0;
      end
    endcase
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.grant_offset = grant_q;
  assign rsp_o.status       = status_q;

endmodule

`default_nettype wire

[tb/tb_first_fit_suballocator.sv]
// Self-checking testbench for the first-fit suballocator: directed and random pool traffic.
module tb_first_fit_suballocator;
  timeunit 1ns;
  timeprecision 1ps;
  import ffs_pkg::*;

  localparam int unsigned FreeSlots   = FreeSlotsDflt;
  // Worst item: the accept, a full list scan and the finish, plus margin
  localparam int unsigned DrainCycles = FreeSlots + 4;
  localparam int unsigned BurstBlocks = 36;
  localparam int unsigned PhaseItems  = 440;
  localparam int unsigned MaxPrinted  = 40;

  // Register 0 holds the pool size; the next word address maps to nothing
  localparam logic [CfgAddrW-1:0] PoolSizeAddr = {RegPoolSize, 2'b00};
  localparam logic [CfgAddrW-1:0] SpareAddr    = {~RegPoolSize, 2'b00};

  typedef logic [DataW-1:0] word_t;

  typedef struct packed {
    kind_e kind;
    word_t size;
    word_t offset;
  } pool_op_t;

  typedef struct packed {
    word_t   grant;
    status_e status;
  } pool_rsp_t;

  // A request waiting for the driver, together with the outcome it must produce
  typedef struct packed {
    pool_op_t  op;
    pool_rsp_t rsp;
  } staged_op_t;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b1;
  logic  psel;
  logic  penable;
  logic  pwrite;
  logic  [CfgAddrW-1:0] paddr;
  word_t pwdata;
  word_t prdata;
  logic  pready;

  ffs_req_if req_bus ();
  ffs_rsp_if rsp_bus ();

  // Shadow pool: free list, bump pointer and the configured pool size
  word_t       free_ofs [FreeSlots];
  word_t       free_len [FreeSlots];
  int unsigned free_cnt   = 0;
  word_t       top_ptr    = '0;
  word_t       pool_bytes = PoolSizeRst;

  staged_op_t op_q[$];
  pool_rsp_t  owed_rsp_q[$];
  staged_op_t next_op;
  pool_rsp_t  offered_rsp;
  pool_rsp_t  want;

  // Blocks the random traffic currently owns and may hand back
  word_t live_ofs[$];
  word_t live_len[$];

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned ops_queued     = 0;
  int unsigned rsp_seen       = 0;
  int unsigned mismatches     = 0;
  int unsigned n_grant        = 0;
  int unsigned n_nospace      = 0;
  int unsigned n_full         = 0;
  int unsigned n_release      = 0;

  task automatic flag_mismatch(input string what);
    if (mismatches < MaxPrinted) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatches++;
  endtask

  // Close the gap at slot idx, keeping the list order
  function automatic void drop_slot(int unsigned idx);
    for (int unsigned j = idx; j + 1 < free_cnt; j++) begin
      free_ofs[j] = free_ofs[j + 1];
      free_len[j] = free_len[j + 1];
    end
    free_cnt--;
  endfunction

  // Apply one request to the shadow pool and return the response it earns
  function automatic pool_rsp_t carve_or_free(pool_op_t op);
    pool_rsp_t   rsp;
    word_t       room;
    word_t       op_end;
    word_t       grow_ofs;
    word_t       grow_len;
    word_t       slot_end;
    word_t       grow_end;
    bit          hit;
    int unsigned i;
    rsp.grant  = '0;
    rsp.status = StOk;
    if (op.kind == KindAlloc) begin
      hit = 1'b0;
      // First fit: a zero-size request takes the first slot whatever its size
      for (i = 0; i < free_cnt; i++) begin
        if (!hit && free_len[i] >= op.size) begin
          hit       = 1'b1;
          rsp.grant = free_ofs[i];
          if (free_len[i] != op.size) begin
            free_ofs[i] = free_ofs[i] + op.size;
            free_len[i] = free_len[i] - op.size;
          end else begin
            drop_slot(i);
          end
        end
      end
      if (!hit) begin
        // A top pointer at or past the pool end leaves no room at all
        room = (pool_bytes > top_ptr) ? pool_bytes - top_ptr : '0;
        if (op.size <= room) begin
          rsp.grant = top_ptr;
          top_ptr   = top_ptr + op.size;
        end else begin
          rsp.status = StNoSpace;
        end
      end
    end else begin
      op_end = op.offset + op.size;
      if (op_end == top_ptr) begin
        // Block ends at the top: lower the pointer, leave the list alone
        top_ptr = top_ptr - op.size;
      end else begin
        grow_ofs = op.offset;
        grow_len = op.size;
        i = 0;
        // One ordered pass; each merge grows the block for the slots after it
        while (i < free_cnt) begin
          slot_end = free_ofs[i] + free_len[i];
          grow_end = grow_ofs + grow_len;
          if (slot_end == grow_ofs || free_ofs[i] == grow_end) begin
            if (free_ofs[i] < grow_ofs) begin
              grow_ofs = free_ofs[i];
            end
            grow_len = free_len[i] + grow_len;
            drop_slot(i);
          end else begin
            i++;
          end
        end
        if (free_cnt >= FreeSlots) begin
          rsp.status = StListFull;
        end else begin
          free_ofs[free_cnt] = grow_ofs;
          free_len[free_cnt] = grow_len;
          free_cnt++;
        end
      end
    end
    return rsp;
  endfunction

  // Predict in queue order; the driver presents requests in that same order
  task automatic queue_op(input kind_e kind, input word_t size, input word_t offset,
                          output pool_rsp_t rsp);
    staged_op_t s;
    s.op.kind   = kind;
    s.op.size   = size;
    s.op.offset = offset;
    rsp   = carve_or_free(s.op);
    s.rsp = rsp;
    op_q.insert(op_q.size(), s);
    ops_queued++;
    if (kind == KindRelease) begin
      n_release++;
    end
    case (rsp.status)
      StNoSpace:  n_nospace++;
      StListFull: n_full++;
      default:    if (kind == KindAlloc) n_grant++;
    endcase
  endtask

  // Hold until every queued request has come back, then let the block settle
  task automatic wait_drained();
    while (rsp_seen != ops_queued) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write one register through setup and access cycles, then read the pool size back
  task automatic cfg_write(input logic [CfgAddrW-1:0] addr, input word_t data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == PoolSizeAddr) begin
      pool_bytes = data;
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PoolSizeAddr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== pool_bytes) begin
      flag_mismatch($sformatf("pool size reads %h, wrote %h", prdata, pool_bytes));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic: mostly well-formed allocate/release pairs, some noise
  task automatic run_traffic(input int unsigned count);
    pool_rsp_t   rsp;
    word_t       sz;
    word_t       ofs;
    int unsigned pick;
    int unsigned idx;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (live_ofs.size() != 0 && (pick < 40 || live_ofs.size() > 48)) begin
        // Hand back an owned block, in random order to fragment the pool
        idx = $urandom_range(live_ofs.size() - 1);
        ofs = live_ofs[idx];
        sz  = live_len[idx];
        live_ofs.delete(idx);
        live_len.delete(idx);
        queue_op(KindRelease, sz, ofs, rsp);
      end else if (pick < 93) begin
        case ($urandom_range(19))
          0:       sz = '0;
          1:       sz = $urandom;
          default: sz = 16 * $urandom_range(1, 64);
        endcase
        // The offset field is ignored on allocate; toggle it anyway
        queue_op(KindAlloc, sz, $urandom, rsp);
        if (rsp.status == StOk && sz != '0) begin
          live_ofs.insert(live_ofs.size(), rsp.grant);
          live_len.insert(live_len.size(), sz);
        end
      end else if (pick < 97) begin
        // Release of a block nobody owns
        queue_op(KindRelease, $urandom, $urandom, rsp);
      end else begin
        queue_op(KindAlloc, $urandom, $urandom, rsp);
      end
    end
  endtask

  always #10 clk_i = ~clk_i;

  first_fit_suballocator u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Request driver: present the next staged request, hold it until the transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid        <= 1'b0;
      req_bus.kind         <= KindAlloc;
      req_bus.block_size   <= '0;
      req_bus.block_offset <= '0;
    end else begin
      // The request on the bus moved: its response is now owed
      if (req_bus.valid && req_bus.ready) begin
        owed_rsp_q.insert(owed_rsp_q.size(), offered_rsp);
      end
      // Advance only when the bus is free or the transfer just happened
      if (!req_bus.valid || req_bus.ready) begin
        if (op_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_op              = op_q.pop_front();
          offered_rsp          = next_op.rsp;
          req_bus.valid        <= 1'b1;
          req_bus.kind         <= next_op.op.kind;
          req_bus.block_size   <= next_op.op.size;
          req_bus.block_offset <= next_op.op.offset;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: check each transfer against the oldest owed response
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (owed_rsp_q.size() == 0) begin
          flag_mismatch($sformatf("response with nothing owed: grant %h status %0d",
                                  rsp_bus.grant_offset, rsp_bus.status));
        end else begin
          want = owed_rsp_q.pop_front();
          if (rsp_bus.grant_offset !== want.grant) begin
            flag_mismatch($sformatf("response %0d grant %h, want %h",
                                    rsp_seen, rsp_bus.grant_offset, want.grant));
          end
          if (rsp_bus.status !== want.status) begin
            flag_mismatch($sformatf("response %0d status %0d, want %0d",
                                    rsp_seen, rsp_bus.status, want.status));
          end
          rsp_seen++;
        end
      end
      // Drop ready at random to stall the response side
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    pool_rsp_t   r;
    word_t       burst_ofs [BurstBlocks];
    word_t       burst_len [BurstBlocks];
    word_t       phase_pool [4];
    int unsigned gap_pct [4];
    int unsigned stall_pct [4];

    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PoolSizeAddr;
    pwdata  <= '0;
    // Falls after every process is waiting, so the driver and monitor see the edge
    rst_ni  <= 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part on the reset pool size, no idling
    queue_op(KindAlloc, 32'h0, 32'hFFFF_FFFF, r);        // zero size from the top
    queue_op(KindAlloc, 32'h100, 32'h0, r);
    queue_op(KindAlloc, 32'h100, 32'h0, r);
    queue_op(KindAlloc, 32'h100, 32'h0, r);
    queue_op(KindAlloc, 32'h100, 32'h0, r);
    queue_op(KindAlloc, 32'h100, 32'h0, r);              // top now at 0x500
    queue_op(KindRelease, 32'h100, 32'h100, r);          // plain append
    queue_op(KindRelease, 32'h100, 32'h300, r);          // plain append
    queue_op(KindRelease, 32'h100, 32'h200, r);          // merge on both sides
    queue_op(KindAlloc, 32'h0, 32'h0, r);                // zero size keeps the slot
    queue_op(KindAlloc, 32'h80, 32'h0, r);               // shrink from the front
    queue_op(KindAlloc, 32'h280, 32'h0, r);              // exact fit removes it
    queue_op(KindRelease, 32'h100, 32'h400, r);          // release at the top
    queue_op(KindAlloc, 32'hFFFF_FFFF, 32'h0, r);        // no space
    queue_op(KindRelease, 32'h0, 32'h5000, r);           // empty slot
    queue_op(KindAlloc, 32'h0, 32'h0, r);                // zero size takes the empty slot
    queue_op(KindRelease, 32'h500, 32'hFFFF_FF00, r);    // end wraps onto the top
    queue_op(KindAlloc, 32'h1, 32'h0, r);                // top past the pool: no room
    queue_op(KindAlloc, 32'h0, 32'h0, r);                // but zero size still fits
    queue_op(KindRelease, 32'hFFFF_FF00, 32'h0, r);      // top back to zero
    queue_op(KindRelease, 32'h20, 32'hFFFF_FFF0, r);     // slot straddling the wrap
    queue_op(KindAlloc, 32'h18, 32'h0, r);               // offset wraps past zero
    queue_op(KindAlloc, 32'h8, 32'h0, r);

    // Pool size extremes, plus a write to an unmapped address
    wait_drained();
    cfg_write(PoolSizeAddr, 32'h0);
    queue_op(KindAlloc, 32'h0, 32'h0, r);
    queue_op(KindAlloc, 32'h10, 32'h0, r);
    wait_drained();
    cfg_write(SpareAddr, $urandom);
    cfg_write(PoolSizeAddr, 32'hFFFF_FFFF);
    queue_op(KindAlloc, 32'hFFFF_FFFF, 32'h0, r);
    queue_op(KindRelease, 32'hFFFF_FFFF, 32'h0, r);

    // Random part: one pool size and one pacing mix per phase
    phase_pool = '{PoolSizeRst, 32'h0001_0000, 32'hFFFF_FFFF,
                   ($urandom & 32'h00FF_FFFF) | 32'h1000};
    gap_pct    = '{0, 56, 0, 15};
    stall_pct  = '{0, 0, 56, 15};
    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      cfg_write(PoolSizeAddr, phase_pool[ph]);
      send_gap_pct   = gap_pct[ph];
      recv_stall_pct = stall_pct[ph];
      if (ph == 0) begin
        // Carve a run of blocks from the top, then free every other one:
        // the list fills up and the last frees overflow it
        for (int unsigned i = 0; i < BurstBlocks; i++) begin
          burst_len[i] = 16 * $urandom_range(1, 16);
          queue_op(KindAlloc, burst_len[i], $urandom, r);
          burst_ofs[i] = r.grant;
        end
        for (int unsigned i = 0; i < BurstBlocks; i += 2) begin
          queue_op(KindRelease, burst_len[i], burst_ofs[i], r);
          live_ofs.insert(live_ofs.size(), burst_ofs[i + 1]);
          live_len.insert(live_len.size(), burst_len[i + 1]);
        end
      end
      run_traffic(PhaseItems);
    end

    wait_drained();
    $display("Checked %0d responses: %0d grants, %0d no-space, %0d list-full, %0d releases",
             rsp_seen, n_grant, n_nospace, n_full, n_release);
    $display("Pool sizes swept from zero to full range under four handshake pacing mixes");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
